FILE: rtl/ata_request_queue_issuer_top_macros.svh
// Assertion macros shared by the queue issuer RTL.
`ifndef ATA_REQUEST_QUEUE_ISSUER_TOP_MACROS_SVH
`define ATA_REQUEST_QUEUE_ISSUER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ARQI_CHECK(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define ARQI_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/arqi_pkg.sv
// Package: types, constants and microcode ROM of the ATA request queue issuer.
`timescale 1ns / 1ps
package arqi_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ATA constants
   localparam logic [7:0] DRV_HEAD_BASE     = 8'hA0;
   localparam logic [7:0] CMD_READ_MULTIPLE = 8'hC4;
   localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
   localparam int         ST_BUSY_BIT       = 7;
   localparam int         ST_DRQ_BIT        = 3;

   // Input item kinds
   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_INTR   = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_CONTROL_BYTE = 2'd0;
   localparam logic [1:0] CSR_LBA_MODE     = 2'd1;
   localparam logic [1:0] CSR_DRIVE_SELECT = 2'd2;

   // Task-file register indexes
   localparam logic [2:0] TF_CONTROL  = 3'd0;
   localparam logic [2:0] TF_COUNT    = 3'd1;
   localparam logic [2:0] TF_SECTOR   = 3'd2;
   localparam logic [2:0] TF_CYL_LOW  = 3'd3;
   localparam logic [2:0] TF_CYL_HIGH = 3'd4;
   localparam logic [2:0] TF_DRV_HEAD = 3'd5;
   localparam logic [2:0] TF_COMMAND  = 3'd6;

   typedef enum logic [1:0] {
      RK_WRITE  = 2'd0,
      RK_DONE   = 2'd1,
      RK_REJECT = 2'd2,
      RK_ERROR  = 2'd3
   } rkind_type;

   // Microcode step addresses
   typedef logic [3:0] upc_type;
   localparam upc_type UPC_WAIT     = 4'd0;
   localparam upc_type UPC_CLASSIFY = 4'd1;
   localparam upc_type UPC_REJECT   = 4'd2;
   localparam upc_type UPC_PUSH     = 4'd3;
   localparam upc_type UPC_ERROR    = 4'd4;
   localparam upc_type UPC_POP_RD   = 4'd5;
   localparam upc_type UPC_DONE     = 4'd6;
   localparam upc_type UPC_ISSUE_RD = 4'd7;
   localparam upc_type UPC_WR_CTRL  = 4'd8;
   localparam upc_type UPC_WR_COUNT = 4'd9;
   localparam upc_type UPC_WR_SECT  = 4'd10;
   localparam upc_type UPC_WR_CYLL  = 4'd11;
   localparam upc_type UPC_WR_CYLH  = 4'd12;
   localparam upc_type UPC_WR_DRVH  = 4'd13;
   localparam upc_type UPC_WR_CMD   = 4'd14;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_CNT_ZERO,
      COND_CNT_ONE,
      COND_DISPATCH
   } cond_type;

   typedef enum logic [2:0] {
      DSEL_NONE,
      DSEL_CONTROL,
      DSEL_COUNT,
      DSEL_LBA0,
      DSEL_LBA1,
      DSEL_LBA2,
      DSEL_DRV_HEAD,
      DSEL_COMMAND
   } dsel_type;

   typedef enum logic [1:0] {
      TSEL_NONE,
      TSEL_ITEM,
      TSEL_RAM
   } tsel_type;

   typedef enum logic [1:0] {
      LSEL_ZERO,
      LSEL_ONE,
      LSEL_CNT_ONE
   } lsel_type;

   // One control word
   typedef struct packed {
      logic      ready;
      logic      emit;
      rkind_type rkind;
      logic [2:0] reg_index;
      dsel_type  dsel;
      tsel_type  tsel;
      lsel_type  lsel;
      logic      push;
      logic      pop;
      cond_type  cond;
      upc_type   tgt;
      upc_type   alt;
   } ucode_type;

   // Sequencer to datapath
   typedef struct packed {
      logic      go;
      ucode_type word;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic accept;
      logic rsp_free;
      logic item_intr;
      logic busy;
      logic drq;
      logic full;
      logic empty;
      logic cnt_one;
   } status_type;

   // Queue entry
   typedef struct packed {
      logic [27:0] lba;
      logic [7:0]  count;
      logic        wr;
      logic [7:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result payload
   typedef struct packed {
      rkind_type  result_kind;
      logic [2:0] reg_index;
      logic [7:0] tf_byte;
      logic [7:0] done_tag;
      logic       last;
   } rsp_type;

   // Microcode ROM
   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      w       = '0;
      w.cond  = COND_ALWAYS;
      w.tgt   = UPC_WAIT;
      w.alt   = UPC_WAIT;
      w.rkind = RK_WRITE;
      unique case (upc)
         UPC_WAIT: begin
            w.ready = 1'b1;
            w.cond  = COND_ACCEPT;
            w.tgt   = UPC_CLASSIFY;
         end
         UPC_CLASSIFY: begin
            w.cond = COND_DISPATCH;
         end
         UPC_REJECT: begin
            w.emit  = 1'b1;
            w.rkind = RK_REJECT;
            w.tsel  = TSEL_ITEM;
            w.lsel  = LSEL_ONE;
         end
         UPC_PUSH: begin
            w.push = 1'b1;
            w.cond = COND_CNT_ZERO;
            w.tgt  = UPC_ISSUE_RD;
         end
         UPC_ERROR: begin
            w.emit  = 1'b1;
            w.rkind = RK_ERROR;
            w.lsel  = LSEL_ONE;
         end
         UPC_POP_RD: begin
            w.tgt = UPC_DONE;
         end
         UPC_DONE: begin
            w.emit  = 1'b1;
            w.rkind = RK_DONE;
            w.tsel  = TSEL_RAM;
            w.lsel  = LSEL_CNT_ONE;
            w.pop   = 1'b1;
            w.cond  = COND_CNT_ONE;
            w.alt   = UPC_ISSUE_RD;
         end
         UPC_ISSUE_RD: begin
            w.tgt = UPC_WR_CTRL;
         end
         UPC_WR_CTRL: begin
            w.emit      = 1'b1;
            w.reg_index = TF_CONTROL;
            w.dsel      = DSEL_CONTROL;
            w.tgt       = UPC_WR_COUNT;
         end
         UPC_WR_COUNT: begin
            w.emit      = 1'b1;
            w.reg_index = TF_COUNT;
            w.dsel      = DSEL_COUNT;
            w.tgt       = UPC_WR_SECT;
         end
         UPC_WR_SECT: begin
            w.emit      = 1'b1;
            w.reg_index = TF_SECTOR;
            w.dsel      = DSEL_LBA0;
            w.tgt       = UPC_WR_CYLL;
         end
         UPC_WR_CYLL: begin
            w.emit      = 1'b1;
            w.reg_index = TF_CYL_LOW;
            w.dsel      = DSEL_LBA1;
            w.tgt       = UPC_WR_CYLH;
         end
         UPC_WR_CYLH: begin
            w.emit      = 1'b1;
            w.reg_index = TF_CYL_HIGH;
            w.dsel      = DSEL_LBA2;
            w.tgt       = UPC_WR_DRVH;
         end
         UPC_WR_DRVH: begin
            w.emit      = 1'b1;
            w.reg_index = TF_DRV_HEAD;
            w.dsel      = DSEL_DRV_HEAD;
            w.tgt       = UPC_WR_CMD;
         end
         UPC_WR_CMD: begin
            w.emit      = 1'b1;
            w.reg_index = TF_COMMAND;
            w.dsel      = DSEL_COMMAND;
            w.lsel      = LSEL_ONE;
         end
         default: begin
            w.tgt = UPC_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/arqi_if.sv
// Interfaces: request and response channels of the queue issuer.
`timescale 1ns / 1ps
interface arqi_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [27:0] block_address;
   logic [7:0]  sector_count;
   logic        is_write;
   logic [7:0]  request_tag;
   logic [7:0]  status_byte;

   modport source (
      output valid, kind, block_address, sector_count, is_write, request_tag,
             status_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, block_address, sector_count, is_write, request_tag,
             status_byte,
      output ready
   );
endinterface

interface arqi_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [2:0] reg_index;
   logic [7:0] tf_byte;
   logic [7:0] done_tag;
   logic       last;

   modport source (
      output valid, result_kind, reg_index, tf_byte, done_tag, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, reg_index, tf_byte, done_tag, last,
      output ready
   );
endinterface

FILE: rtl/arqi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module arqi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/arqi_seq.sv
// Microcode sequencer: step counter, control ROM and branch selection.
`timescale 1ns / 1ps
module arqi_seq
   import arqi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);
   upc_type   upc_ff;
   upc_type   upc_in;
   upc_type   dispatch_tgt;
   ucode_type word;
   logic      go;
   logic      cond_true;

   // Fetch the control word of the current step
   assign word = ucode_rom(upc_ff);

   // Stall an emitting step while the output register is occupied
   assign go = !word.emit || status.rsp_free;

   // Multiway branch on the latched item
   always_comb begin
      priority if (!status.item_intr) begin
         dispatch_tgt = status.full ? UPC_REJECT : UPC_PUSH;
      end else if (status.busy) begin
         dispatch_tgt = UPC_WAIT;
      end else if (!status.drq || status.empty) begin
         dispatch_tgt = UPC_ERROR;
      end else begin
         dispatch_tgt = UPC_POP_RD;
      end
   end

   // Evaluate the branch condition
   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_ACCEPT:   cond_true = status.accept;
         COND_CNT_ZERO: cond_true = status.empty;
         COND_CNT_ONE:  cond_true = status.cnt_one;
         COND_DISPATCH: cond_true = 1'b1;
         default:       cond_true = 1'b1;
      endcase
   end

   // Select the next step
   always_comb begin
      upc_in = upc_ff;
      if (go) begin
         if (word.cond == COND_DISPATCH) begin
            upc_in = dispatch_tgt;
         end else begin
            upc_in = cond_true ? word.tgt : word.alt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl.go   = go;
   assign ctrl.word = word;
endmodule

FILE: rtl/ata_request_queue_issuer_top.sv
// Top level of the ATA LBA28 request queue and command issuer.
//
// Usage:
//   req_ch takes one item per transfer: a submit (LBA, count, read/write, tag)
//   or a drive interrupt (status byte). rsp_ch gives the results: task-file
//   register writes, done, reject and error; last marks the final result of
//   an item. csr_* writes control_byte, lba_mode and drive_select; write
//   them only while the block is idle.
//   A microcoded sequencer runs one control step per cycle, except while an
//   emitting step waits for the output register, and places at most one
//   result per cycle in the output register. An ignored interrupt runs the
//   wait and classify steps; a queued submit, reject or error ends in its
//   push, reject or error step; a done runs pop-read and done and, when
//   entries remain, issue-read and the seven writes of the next command; a
//   submit to an empty queue runs push, issue-read and then the seven writes.
//   Reset empties the queue and loads the register defaults; items are taken
//   from the first cycle after reset drops.
//   When rsp_ch stalls, the output register holds its result and the
//   sequencer waits on its emitting step; req_ch.ready stays low until the
//   item is finished.
`timescale 1ns / 1ps
`include "ata_request_queue_issuer_top_macros.svh"
module ata_request_queue_issuer_top
   import arqi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   arqi_req_if.sink    req_ch,
   arqi_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   ctrl_type   ctrl;
   status_type status;
   logic       accept;

   // Latched item
   logic      item_kind_ff,  item_kind_in;
   logic      item_busy_ff,  item_busy_in;
   logic      item_drq_ff,   item_drq_in;
   entry_type item_ent_ff,   item_ent_in;

   // Queue control
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   entry_type        head_ent;
   logic [ENTRY_W-1:0] ram_rdata;

   // Configuration
   logic [7:0] control_byte_ff, control_byte_in;
   logic       lba_mode_ff,     lba_mode_in;
   logic       drive_select_ff, drive_select_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;
   logic    load_rsp;
   logic [7:0] wr_data;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = ctrl.word.ready;

   // Status to the sequencer
   assign status.accept    = accept;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign status.item_intr = (item_kind_ff == KIND_INTR);
   assign status.busy      = item_busy_ff;
   assign status.drq       = item_drq_ff;
   assign status.full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty     = (cnt_ff == '0);
   assign status.cnt_one   = (cnt_ff == CNT_W'(1));

   arqi_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Capture the item on transfer
   always_comb begin
      item_kind_in = item_kind_ff;
      item_busy_in = item_busy_ff;
      item_drq_in  = item_drq_ff;
      item_ent_in  = item_ent_ff;
      if (accept) begin
         item_kind_in      = req_ch.kind;
         item_busy_in      = req_ch.status_byte[ST_BUSY_BIT];
         item_drq_in       = req_ch.status_byte[ST_DRQ_BIT];
         item_ent_in.lba   = req_ch.block_address;
         item_ent_in.count = req_ch.sector_count;
         item_ent_in.wr    = req_ch.is_write;
         item_ent_in.tag   = req_ch.request_tag;
      end
   end

   always_ff @(posedge clock) begin
      item_kind_ff <= item_kind_in;
      item_busy_ff <= item_busy_in;
      item_drq_ff  <= item_drq_in;
      item_ent_ff  <= item_ent_in;
   end

   // Advance pointers and count on push and pop
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (ctrl.go && ctrl.word.push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         cnt_in  = cnt_ff + CNT_W'(1);
      end else if (ctrl.go && ctrl.word.pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         cnt_in  = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Queue storage, read continuously at the head
   arqi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ctrl.go && ctrl.word.push),
      .wr_addr (tail_ff),
      .wr_data (item_ent_ff),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign head_ent = entry_type'(ram_rdata);

   // Configuration writes
   always_comb begin
      control_byte_in = control_byte_ff;
      lba_mode_in     = lba_mode_ff;
      drive_select_in = drive_select_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CONTROL_BYTE: control_byte_in = csr_wdata;
            CSR_LBA_MODE:     lba_mode_in     = csr_wdata[0];
            CSR_DRIVE_SELECT: drive_select_in = csr_wdata[0];
            default:          control_byte_in = control_byte_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_byte_ff <= 8'd8;
         lba_mode_ff     <= 1'b1;
         drive_select_ff <= 1'b0;
      end else begin
         control_byte_ff <= control_byte_in;
         lba_mode_ff     <= lba_mode_in;
         drive_select_ff <= drive_select_in;
      end
   end

   // Select the task-file byte
   always_comb begin
      unique case (ctrl.word.dsel)
         DSEL_NONE:     wr_data = 8'h00;
         DSEL_CONTROL:  wr_data = control_byte_ff;
         DSEL_COUNT:    wr_data = head_ent.count;
         DSEL_LBA0:     wr_data = head_ent.lba[7:0];
         DSEL_LBA1:     wr_data = head_ent.lba[15:8];
         DSEL_LBA2:     wr_data = head_ent.lba[23:16];
         DSEL_DRV_HEAD: wr_data = DRV_HEAD_BASE
                                  | {1'b0, lba_mode_ff, 1'b0, drive_select_ff, 4'h0}
                                  | {4'h0, head_ent.lba[27:24]};
         DSEL_COMMAND:  wr_data = head_ent.wr ? CMD_WRITE_SECTORS : CMD_READ_MULTIPLE;
         default:       wr_data = 8'h00;
      endcase
   end

   // Load the output register on an emitting step, drop it on transfer
   assign load_rsp = ctrl.go && ctrl.word.emit;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = ctrl.word.rkind;
         rsp_in.reg_index   = ctrl.word.reg_index;
         rsp_in.tf_byte     = wr_data;
         unique case (ctrl.word.tsel)
            TSEL_NONE: rsp_in.done_tag = 8'h00;
            TSEL_ITEM: rsp_in.done_tag = item_ent_ff.tag;
            TSEL_RAM:  rsp_in.done_tag = head_ent.tag;
            default:   rsp_in.done_tag = 8'h00;
         endcase
         unique case (ctrl.word.lsel)
            LSEL_ZERO:    rsp_in.last = 1'b0;
            LSEL_ONE:     rsp_in.last = 1'b1;
            LSEL_CNT_ONE: rsp_in.last = status.cnt_one;
            default:      rsp_in.last = 1'b0;
         endcase
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_ff.result_kind;
   assign rsp_ch.reg_index   = rsp_ff.reg_index;
   assign rsp_ch.tf_byte     = rsp_ff.tf_byte;
   assign rsp_ch.done_tag    = rsp_ff.done_tag;
   assign rsp_ch.last        = rsp_ff.last;

   // Checks
   `ARQI_CHECK(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH), "count high")
   `ARQI_CHECK(a_push_not_full, clock, reset, ctrl.go && ctrl.word.push, !status.full, "full")
   `ARQI_CHECK(a_pop_not_empty, clock, reset, ctrl.go && ctrl.word.pop, !status.empty, "empty")
   `ARQI_CHECK_NEXT(a_busy_after_accept, clock, reset, accept, !req_ch.ready, "ready high")
endmodule
